// ===== rtl/bgu_pkg.sv =====
// Shared constants, types and codes of the bilinear grid upsampler.
package bgu_pkg;

  localparam int MAX_GRID_SIDE = 32;
  localparam int GRID_DEPTH    = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int GRID_AW       = $clog2(GRID_DEPTH);
  localparam int IDX_W         = $clog2(MAX_GRID_SIDE);
  localparam int MAX_HALF_SPAN = (MAX_GRID_SIDE - 1) / 2;

  localparam int HALF_W  = 4;
  localparam int CELL_W  = 8;
  localparam int GPOS_W  = 5;
  localparam int VAL_W   = 32;
  localparam int PIX_W   = 13;
  localparam int WGT_W   = 2 * CELL_W;
  localparam int ACC_W   = 48;
  localparam int CFG_AW  = 2;

  localparam int DIV_NUM_W  = ACC_W;
  localparam int DIV_DEN_W  = WGT_W;
  localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

  localparam logic [CFG_AW-1:0] CFG_HALF_SPAN   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CELL_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CELL_HEIGHT = 2'd2;

  localparam logic [HALF_W-1:0] RST_HALF_SPAN = 4'd10;
  localparam logic [CELL_W-1:0] RST_CELL_SIZE = 8'd32;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  localparam logic [2:0] MAC_LAST = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_ROW,
    S_DIV_COL,
    S_MAC,
    S_DIV_ACC,
    S_OUT
  } bgu_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  dividend;
    logic [DIV_DEN_W-1:0]  divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/bgu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bgu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bgu_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend aligned to the top.
module bgu_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bgu_pkg::div_req_t req_i,
  output bgu_pkg::div_rsp_t rsp_o
);
  import bgu_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0]  num_q, num_d;
  logic [DIV_DEN_W-1:0]  rem_q, rem_d;
  logic [DIV_DEN_W-1:0]  den_q, den_d;
  logic [DIV_DEN_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q, num_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      num_d = {num_q[DIV_NUM_W-2:0], ge};
      rem_d = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/bilinear_grid_upsampler_unit.sv =====
// Top level: grid store, sequencer, multiply-accumulate and result register.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | opcode, grid_row/col/value, pixel_row/col
//   out     | out_valid_o / out_stall_i | pixel_value, status
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load item is written as it is accepted. An in-range sample runs two divisions
// with 13-bit quotients for the cell indices, four grid reads through the single
// read port with the multiply-accumulate, and a division with a 48-bit quotient
// by the cell area, all on the one shared bit-serial divider. An out-of-range
// sample goes straight to the output state. Reset needs no clearing pass. A
// stalled result waits in the output register while the next item is taken.
module bilinear_grid_upsampler_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 opcode_i,
  input  logic        [bgu_pkg::GPOS_W-1:0]    grid_row_i,
  input  logic        [bgu_pkg::GPOS_W-1:0]    grid_col_i,
  input  logic signed [bgu_pkg::VAL_W-1:0]     grid_value_i,
  input  logic        [bgu_pkg::PIX_W-1:0]     pixel_row_i,
  input  logic        [bgu_pkg::PIX_W-1:0]     pixel_col_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [bgu_pkg::VAL_W-1:0]     pixel_value_o,
  output logic                                 status_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [bgu_pkg::CFG_AW-1:0]    cfg_index_i,
  input  logic        [bgu_pkg::CELL_W-1:0]    cfg_data_i
);
  import bgu_pkg::*;

  bgu_state_e state_q, state_d;

  logic [HALF_W-1:0] half_q;
  logic [CELL_W-1:0] cell_w_q, cell_h_q;

  logic [PIX_W-1:0]  col_q;
  logic [IDX_W-1:0]  k_q, l_q;
  logic [CELL_W-1:0] i_q, j_q;
  logic [2:0]        mac_cnt_q, mac_cnt_d;
  logic [WGT_W-1:0]  weight_q, weight_d;
  logic signed [ACC_W-1:0] prod_q, acc_q, acc_d;
  logic signed [ACC_W:0]   prod_full;
  logic [ACC_W-1:0]        acc_mag;
  logic signed [VAL_W-1:0] res_q, res_d, quot_s;
  logic                    res_status_q, res_status_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] pixel_value_q;
  logic                    status_q;

  logic              in_acc, is_sample, smp_ok, out_free;
  logic [HALF_W-1:0] n_sat;
  logic [PIX_W-1:0]  row_lim, col_lim;
  logic [CELL_W-1:0] fac_a, fac_b;
  logic [IDX_W-1:0]  kk, ll;
  logic [WGT_W-1:0]  area;

  logic               ram_we;
  logic [GRID_AW-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign is_sample = opcode_i == OP_SAMPLE;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign n_sat   = (2 * int'(half_q) + 1 > MAX_GRID_SIDE) ? HALF_W'(MAX_HALF_SPAN) : half_q;
  assign row_lim = PIX_W'({n_sat, 1'b0}) * PIX_W'(cell_h_q);
  assign col_lim = PIX_W'({n_sat, 1'b0}) * PIX_W'(cell_w_q);
  assign smp_ok  = (n_sat != '0) && (cell_h_q != '0) && (cell_w_q != '0) &&
                   (pixel_row_i < row_lim) && (pixel_col_i < col_lim);

  // corner order: UL, UR, LL, LR; bit 1 steps the row, bit 0 the column
  assign fac_a    = mac_cnt_q[1] ? i_q : CELL_W'(cell_h_q - i_q);
  assign fac_b    = mac_cnt_q[0] ? j_q : CELL_W'(cell_w_q - j_q);
  assign weight_d = WGT_W'(fac_a) * WGT_W'(fac_b);
  assign kk       = k_q + IDX_W'(mac_cnt_q[1]);
  assign ll       = l_q + IDX_W'(mac_cnt_q[0]);
  assign ram_raddr = GRID_AW'(int'(kk) * MAX_GRID_SIDE + int'(ll));
  assign ram_waddr = GRID_AW'(int'(grid_row_i) * MAX_GRID_SIDE + int'(grid_col_i));

  assign prod_full = $signed(ram_rdata) * $signed({1'b0, weight_q});
  assign acc_mag   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign area      = WGT_W'(cell_h_q) * WGT_W'(cell_w_q);
  assign quot_s    = $signed(div_rsp.quot[VAL_W-1:0]);

  bgu_ram #(
    .WIDTH(VAL_W),
    .DEPTH(GRID_DEPTH)
  ) u_grid_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(grid_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bgu_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && is_sample) begin
          state_d = smp_ok ? S_DIV_ROW : S_OUT;
        end
      end
      S_DIV_ROW: begin
        if (div_rsp.done) begin
          state_d = S_DIV_COL;
        end
      end
      S_DIV_COL: begin
        if (div_rsp.done) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (mac_cnt_q == MAC_LAST) begin
          state_d = S_DIV_ACC;
        end
      end
      S_DIV_ACC: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o       = 1'b1;
    ram_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {pixel_row_i, (DIV_NUM_W - PIX_W)'(0)};
    div_req.divisor  = DIV_DEN_W'(cell_h_q);
    div_req.steps    = DIV_STEP_W'(PIX_W);
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        ram_we        = in_acc && !is_sample &&
                        (int'(grid_row_i) < MAX_GRID_SIDE) &&
                        (int'(grid_col_i) < MAX_GRID_SIDE);
        div_req.start = in_acc && is_sample && smp_ok;
      end
      S_DIV_ROW: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {col_q, (DIV_NUM_W - PIX_W)'(0)};
        div_req.divisor  = DIV_DEN_W'(cell_w_q);
      end
      S_MAC: begin
        div_req.start    = mac_cnt_q == MAC_LAST;
        div_req.dividend = acc_mag;
        div_req.divisor  = area;
        div_req.steps    = DIV_STEP_W'(DIV_NUM_W);
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    mac_cnt_d    = mac_cnt_q;
    acc_d        = acc_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        res_d        = '0;
        res_status_d = ST_RANGE;
      end
      S_DIV_COL: begin
        mac_cnt_d = '0;
        acc_d     = '0;
      end
      S_MAC: begin
        mac_cnt_d = mac_cnt_q + 3'd1;
        if (mac_cnt_q >= 3'd2 && mac_cnt_q <= 3'd5) begin
          acc_d = acc_q + prod_q;
        end
      end
      S_DIV_ACC: begin
        res_d        = acc_q[ACC_W-1] ? -quot_s : quot_s;
        res_status_d = ST_OK;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mac_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      half_q      <= RST_HALF_SPAN;
      cell_w_q    <= RST_CELL_SIZE;
      cell_h_q    <= RST_CELL_SIZE;
    end else begin
      state_q     <= state_d;
      mac_cnt_q   <= mac_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_HALF_SPAN:   half_q   <= cfg_data_i[HALF_W-1:0];
          CFG_CELL_WIDTH:  cell_w_q <= cfg_data_i;
          CFG_CELL_HEIGHT: cell_h_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      col_q <= pixel_col_i;
    end
    if (state_q == S_DIV_ROW && div_rsp.done) begin
      k_q <= div_rsp.quot[IDX_W-1:0];
      i_q <= div_rsp.rem[CELL_W-1:0];
    end
    if (state_q == S_DIV_COL && div_rsp.done) begin
      l_q <= div_rsp.quot[IDX_W-1:0];
      j_q <= div_rsp.rem[CELL_W-1:0];
    end
    weight_q     <= weight_d;
    prod_q       <= prod_full[ACC_W-1:0];
    acc_q        <= acc_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
    if (state_q == S_OUT && out_free) begin
      pixel_value_q <= res_q;
      status_q      <= res_status_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_value_q;
  assign status_o      = status_q;

endmodule
